// ===== sv/lmn_pkg.sv =====
// ----------------------------------------------------------------------------
// lmn_pkg
// Types, codes and sizes shared by the Lamport mutual exclusion node.
// ----------------------------------------------------------------------------
`default_nettype none

package lmn_pkg;

  localparam int MAX_NODES = 8;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int TIME_W    = 32;
  localparam int RANK_W    = 3;
  localparam int NCNT_W    = 4;
  localparam int ENTRY_W   = TIME_W + RANK_W;

  localparam logic [TIME_W-1:0] CLOCK_MAX = '1;
  localparam logic [NCNT_W-1:0] CTR_MAX   = '1;

  localparam logic [2:0] TY_RX_REQ  = 3'd0;
  localparam logic [2:0] TY_RX_REP  = 3'd1;
  localparam logic [2:0] TY_RX_REL  = 3'd2;
  localparam logic [2:0] TY_RX_FIN  = 3'd3;
  localparam logic [2:0] TY_LOC_REQ = 3'd4;
  localparam logic [2:0] TY_LOC_REL = 3'd5;
  localparam logic [2:0] TY_LOC_FIN = 3'd6;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_REPLY   = 3'd1;
  localparam logic [2:0] KIND_REQUEST = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_FIN     = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ADD     = 2'd1;
  localparam logic [1:0] ERR_MISSING = 2'd2;

  localparam logic CFG_OWN_RANK   = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [RANK_W-1:0] src_rank;
    logic [TIME_W-1:0] msg_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        send_kind;
    logic [RANK_W-1:0] send_dest;
    logic [TIME_W-1:0] send_time;
    logic              grant;
    logic              all_finished;
    logic [1:0]        error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_APPLY = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    return (v == CLOCK_MAX) ? v : v + TIME_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/lamport_mutex_node.sv =====
// ----------------------------------------------------------------------------
// lamport_mutex_node
// One node of Lamport distributed mutual exclusion with a request table.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one event and yields exactly
// one result transaction. The request table is held in a small synchronous
// memory and is walked one entry per cycle: an event that adds or removes an
// entry takes one sweep over all MAX_NODES slots to look for a duplicate or
// the entry to remove, and when the node is waiting with enough replies a
// second sweep of the same length finds the front of the table. The result
// register may then wait on out_stall, and no new event is taken until the
// node is back in idle with the result registered. Configuration is taken
// at any time on the cfg port and must only be written while no event is in
// flight.
`default_nettype none

module lamport_mutex_node (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lmn_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lmn_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [3:0]        cfg_wdata
);

  localparam int IDX_W   = lmn_pkg::IDX_W;
  localparam int CNT_W   = lmn_pkg::CNT_W;
  localparam int TIME_W  = lmn_pkg::TIME_W;
  localparam int RANK_W  = lmn_pkg::RANK_W;
  localparam int NCNT_W  = lmn_pkg::NCNT_W;
  localparam int ENTRY_W = lmn_pkg::ENTRY_W;
  localparam int CMP_W   = (CNT_W > NCNT_W) ? CNT_W : NCNT_W;
  localparam logic [IDX_W:0] LAST   = (IDX_W + 1)'(lmn_pkg::MAX_NODES);
  localparam logic [CMP_W-1:0] MAXN = CMP_W'(lmn_pkg::MAX_NODES);

  lmn_pkg::state_t state_r, state_nxt;
  logic [IDX_W:0]                    cnt_r, cnt_nxt;
  logic                              live_r, live_nxt;
  logic [IDX_W-1:0]                  idx_r;
  logic [ENTRY_W-1:0]                rd_data_r;
  logic [ENTRY_W-1:0]                mem [lmn_pkg::MAX_NODES];

  logic [2:0]                        ty_r, ty_nxt;
  logic [RANK_W-1:0]                 sender_r, sender_nxt;
  logic [TIME_W-1:0]                 key_time_r, key_time_nxt;
  logic [RANK_W-1:0]                 key_rank_r, key_rank_nxt;
  logic [TIME_W-1:0]                 clock_r, clock_nxt;
  logic [NCNT_W-1:0]                 rc_r, rc_nxt;
  logic [NCNT_W-1:0]                 fc_r, fc_nxt;
  logic                              waiting_r, waiting_nxt;
  logic [lmn_pkg::MAX_NODES-1:0]     valid_r, valid_nxt;
  logic [RANK_W-1:0]                 own_rank_r, own_rank_nxt;
  logic [NCNT_W-1:0]                 node_count_r, node_count_nxt;

  logic                              best_v_r, best_v_nxt;
  logic [TIME_W-1:0]                 best_time_r, best_time_nxt;
  logic [RANK_W-1:0]                 best_rank_r, best_rank_nxt;
  logic [IDX_W-1:0]                  best_idx_r, best_idx_nxt;
  logic                              dup_r, dup_nxt;
  logic                              need_r, need_nxt;

  logic [2:0]                        res_kind_r, res_kind_nxt;
  logic [RANK_W-1:0]                 res_dest_r, res_dest_nxt;
  logic [TIME_W-1:0]                 res_time_r, res_time_nxt;
  logic [1:0]                        res_err_r, res_err_nxt;

  logic                              out_valid_r, out_valid_nxt;
  lmn_pkg::out_item_t                out_data_r, out_data_nxt;

  logic                              rd_en;
  logic                              mem_we;
  logic [IDX_W-1:0]                  mem_wa;
  logic [ENTRY_W-1:0]                mem_wd;
  logic [TIME_W-1:0]                 e_time;
  logic [RANK_W-1:0]                 e_rank;
  logic                              e_v;
  logic                              filter;
  logic                              better;
  logic                              is_add;
  logic                              is_rem;
  logic [CNT_W-1:0]                  used;
  logic [IDX_W-1:0]                  free_idx;
  logic [CMP_W-1:0]                  cap;
  logic [NCNT_W-1:0]                 thr;
  logic                              out_free;
  logic                              grant_w;
  logic [TIME_W-1:0]                 inc_clock;
  logic [TIME_W-1:0]                 inc_msg;

  assign in_stall  = (state_r != lmn_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_add = (ty_r == lmn_pkg::TY_RX_REQ) || (ty_r == lmn_pkg::TY_LOC_REQ);
  assign is_rem = (ty_r == lmn_pkg::TY_RX_REL) || (ty_r == lmn_pkg::TY_LOC_REL);

  assign e_time = rd_data_r[ENTRY_W-1:RANK_W];
  assign e_rank = rd_data_r[RANK_W-1:0];
  assign e_v    = live_r && valid_r[idx_r];
  assign filter = (state_r == lmn_pkg::S_SCAN1) && is_rem;
  assign better = !best_v_r || (e_time < best_time_r) ||
                  ((e_time == best_time_r) && (e_rank < best_rank_r));

  assign used = CNT_W'($countones(valid_r));
  assign cap  = (CMP_W'(node_count_r) < MAXN) ? CMP_W'(node_count_r) : MAXN;
  assign thr  = (node_count_r == '0) ? '0 : node_count_r - NCNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign grant_w  = need_r && best_v_r && (best_rank_r == own_rank_r);
  assign inc_clock = lmn_pkg::sat_inc(clock_r);
  assign inc_msg   = lmn_pkg::sat_inc(in_data.msg_time);

  always_comb begin
    free_idx = '0;
    for (int i = lmn_pkg::MAX_NODES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ty_nxt         = ty_r;
    sender_nxt     = sender_r;
    key_time_nxt   = key_time_r;
    key_rank_nxt   = key_rank_r;
    clock_nxt      = clock_r;
    rc_nxt         = rc_r;
    fc_nxt         = fc_r;
    waiting_nxt    = waiting_r;
    valid_nxt      = valid_r;
    own_rank_nxt   = own_rank_r;
    node_count_nxt = node_count_r;
    best_v_nxt     = best_v_r;
    best_time_nxt  = best_time_r;
    best_rank_nxt  = best_rank_r;
    best_idx_nxt   = best_idx_r;
    dup_nxt        = dup_r;
    need_nxt       = need_r;
    res_kind_nxt   = res_kind_r;
    res_dest_nxt   = res_dest_r;
    res_time_nxt   = res_time_r;
    res_err_nxt    = res_err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = free_idx;
    mem_wd         = {key_time_r, key_rank_r};

    rd_en    = ((state_r == lmn_pkg::S_SCAN1) || (state_r == lmn_pkg::S_SCAN2)) &&
               (cnt_r < LAST);
    live_nxt = rd_en;

    if (e_v && (!filter || (e_rank == key_rank_r)) && better) begin
      best_v_nxt    = 1'b1;
      best_time_nxt = e_time;
      best_rank_nxt = e_rank;
      best_idx_nxt  = idx_r;
    end
    if (e_v && (e_time == key_time_r) && (e_rank == key_rank_r)) begin
      dup_nxt = 1'b1;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lmn_pkg::CFG_OWN_RANK:   own_rank_nxt   = cfg_wdata[RANK_W-1:0];
        lmn_pkg::CFG_NODE_COUNT: node_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      lmn_pkg::S_IDLE: begin
        if (in_valid) begin
          ty_nxt       = in_data.req_type;
          sender_nxt   = in_data.src_rank;
          key_time_nxt = in_data.msg_time;
          key_rank_nxt = in_data.src_rank;
          best_v_nxt   = 1'b0;
          dup_nxt      = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = lmn_pkg::S_APPLY;
          if (in_data.req_type <= lmn_pkg::TY_RX_FIN) begin
            clock_nxt = (inc_clock > inc_msg) ? inc_clock : inc_msg;
          end else if (in_data.req_type <= lmn_pkg::TY_LOC_FIN) begin
            clock_nxt = inc_clock;
          end
          unique case (in_data.req_type)
            lmn_pkg::TY_RX_REQ, lmn_pkg::TY_RX_REL: begin
              state_nxt = lmn_pkg::S_SCAN1;
            end
            lmn_pkg::TY_RX_REP: begin
              if (waiting_r && (rc_r != lmn_pkg::CTR_MAX)) begin
                rc_nxt = rc_r + NCNT_W'(1);
              end
            end
            lmn_pkg::TY_RX_FIN: begin
              if (fc_r != lmn_pkg::CTR_MAX) begin
                fc_nxt = fc_r + NCNT_W'(1);
              end
            end
            lmn_pkg::TY_LOC_REQ: begin
              key_time_nxt = inc_clock;
              key_rank_nxt = own_rank_r;
              rc_nxt       = '0;
              waiting_nxt  = 1'b1;
              state_nxt    = lmn_pkg::S_SCAN1;
            end
            lmn_pkg::TY_LOC_REL: begin
              key_rank_nxt = own_rank_r;
              waiting_nxt  = 1'b0;
              state_nxt    = lmn_pkg::S_SCAN1;
            end
            default: ;
          endcase
        end
      end
      lmn_pkg::S_SCAN1: begin
        cnt_nxt = cnt_r + (IDX_W + 1)'(1);
        if (cnt_r == LAST) begin
          state_nxt = lmn_pkg::S_APPLY;
        end
      end
      lmn_pkg::S_APPLY: begin
        res_err_nxt  = lmn_pkg::ERR_NONE;
        res_kind_nxt = lmn_pkg::KIND_NONE;
        res_dest_nxt = '0;
        res_time_nxt = '0;
        if (is_add) begin
          if ((CMP_W'(key_rank_r) >= CMP_W'(node_count_r)) || (CMP_W'(used) >= cap)) begin
            res_err_nxt = lmn_pkg::ERR_ADD;
          end else if (!dup_r) begin
            mem_we              = 1'b1;
            valid_nxt[free_idx] = 1'b1;
          end
        end
        if (is_rem) begin
          if (best_v_r) begin
            valid_nxt[best_idx_r] = 1'b0;
          end else begin
            res_err_nxt = lmn_pkg::ERR_MISSING;
          end
        end
        if (ty_r == lmn_pkg::TY_RX_REQ) begin
          clock_nxt    = inc_clock;
          res_kind_nxt = lmn_pkg::KIND_REPLY;
          res_dest_nxt = sender_r;
          res_time_nxt = inc_clock;
        end else if ((ty_r >= lmn_pkg::TY_LOC_REQ) && (ty_r <= lmn_pkg::TY_LOC_FIN)) begin
          res_time_nxt = clock_r;
          if (ty_r == lmn_pkg::TY_LOC_REQ) begin
            res_kind_nxt = lmn_pkg::KIND_REQUEST;
          end else if (ty_r == lmn_pkg::TY_LOC_REL) begin
            res_kind_nxt = lmn_pkg::KIND_RELEASE;
          end else begin
            res_kind_nxt = lmn_pkg::KIND_FIN;
          end
        end
        need_nxt   = waiting_r && (rc_r >= thr);
        best_v_nxt = 1'b0;
        cnt_nxt    = '0;
        state_nxt  = (waiting_r && (rc_r >= thr)) ? lmn_pkg::S_SCAN2 : lmn_pkg::S_DONE;
      end
      lmn_pkg::S_SCAN2: begin
        cnt_nxt = cnt_r + (IDX_W + 1)'(1);
        if (cnt_r == LAST) begin
          state_nxt = lmn_pkg::S_DONE;
        end
      end
      lmn_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.send_kind    = res_kind_r;
          out_data_nxt.send_dest    = res_dest_r;
          out_data_nxt.send_time    = res_time_r;
          out_data_nxt.grant        = grant_w;
          out_data_nxt.all_finished = (fc_r >= thr);
          out_data_nxt.error_code   = res_err_r;
          if (grant_w) begin
            waiting_nxt = 1'b0;
          end
          state_nxt = lmn_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lmn_pkg::S_IDLE;
      cnt_r        <= '0;
      live_r       <= 1'b0;
      clock_r      <= '0;
      rc_r         <= '0;
      fc_r         <= '0;
      waiting_r    <= 1'b0;
      valid_r      <= '0;
      own_rank_r   <= '0;
      node_count_r <= NCNT_W'(8);
      best_v_r     <= 1'b0;
      dup_r        <= 1'b0;
      need_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      live_r       <= live_nxt;
      clock_r      <= clock_nxt;
      rc_r         <= rc_nxt;
      fc_r         <= fc_nxt;
      waiting_r    <= waiting_nxt;
      valid_r      <= valid_nxt;
      own_rank_r   <= own_rank_nxt;
      node_count_r <= node_count_nxt;
      best_v_r     <= best_v_nxt;
      dup_r        <= dup_nxt;
      need_r       <= need_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= cnt_r[IDX_W-1:0];
    ty_r        <= ty_nxt;
    sender_r    <= sender_nxt;
    key_time_r  <= key_time_nxt;
    key_rank_r  <= key_rank_nxt;
    best_time_r <= best_time_nxt;
    best_rank_r <= best_rank_nxt;
    best_idx_r  <= best_idx_nxt;
    res_kind_r  <= res_kind_nxt;
    res_dest_r  <= res_dest_nxt;
    res_time_r  <= res_time_nxt;
    res_err_r   <= res_err_nxt;
    out_data_r  <= out_data_nxt;
  end

  // A local release never grants the critical section.
  a_release_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.send_kind == lmn_pkg::KIND_RELEASE)) |-> !out_data.grant)
    else $error("grant raised on a local release");

  // An accepted transaction keeps the node busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // The table memory is never written during a sweep.
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == lmn_pkg::S_SCAN1) || (state_r == lmn_pkg::S_SCAN2)) |-> !mem_we)
    else $error("table written during a sweep");

  // Applying an event changes the table occupancy by at most one entry.
  a_one_entry_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmn_pkg::S_APPLY) |=>
      (($countones(valid_r) == $past($countones(valid_r))) ||
       ($countones(valid_r) == $past($countones(valid_r)) + 1) ||
       ($countones(valid_r) + 1 == $past($countones(valid_r)))))
    else $error("table occupancy changed by more than one entry");

endmodule

`default_nettype wire
